[rtl/running_sample_std_dev_assert.svh]
// Assertion macros used by the port-level checker of the running standard deviation block.
`ifndef RUNNING_SAMPLE_STD_DEV_ASSERT_SVH
`define RUNNING_SAMPLE_STD_DEV_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define RSD_ASSERT_IMP(lbl, rst, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error("running_sample_std_dev: same-cycle check failed");

// Check a consequence in the cycle after its antecedent.
`define RSD_ASSERT_NXT(lbl, rst, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error("running_sample_std_dev: next-cycle check failed");

`endif

[rtl/rsd_pkg.sv]
// Shared constants and types of the running standard deviation block.
`default_nettype none

package rsd_pkg;

   // Default sizes of a sample and of the sample counter
   localparam int DEF_SAMPLE_WIDTH = 16;
   localparam int DEF_COUNT_WIDTH  = 16;

   // Result field width and its saturation value
   localparam int OUT_W   = 16;
   localparam int OUT_MAX = (2 ** OUT_W) - 1;

   // Entries in the queue between accumulation and evaluation
   localparam int QUEUE_DEPTH = 2;

   // Flags of one request transaction, accept in the lowest bit
   typedef struct packed {
      logic report;
      logic restart;
      logic accept;
   } rsd_flags_type;

   // One result, sample_count in the lowest bits
   typedef struct packed {
      logic             saturated;
      logic             missing;
      logic [OUT_W-1:0] std_dev;
      logic [OUT_W-1:0] sample_count;
   } rsd_result_type;

endpackage

`default_nettype wire

[rtl/rsd_front.sv]
// Front end: takes samples, keeps count, sum and sum of squares, queues report snapshots.
`default_nettype none

module rsd_front #(
   parameter int SAMPLE_WIDTH = rsd_pkg::DEF_SAMPLE_WIDTH,
   parameter int COUNT_WIDTH  = rsd_pkg::DEF_COUNT_WIDTH,
   parameter int SNAP_W       = COUNT_WIDTH + (SAMPLE_WIDTH + COUNT_WIDTH)
                                + (2 * SAMPLE_WIDTH - 1 + COUNT_WIDTH) + 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [SAMPLE_WIDTH-1:0]   req_sample,
   input  wire rsd_pkg::rsd_flags_type    req_flags,
   output logic                           snap_valid,
   input  wire logic                      snap_ready,
   output logic [SNAP_W-1:0]              snap_data
);
   import rsd_pkg::*;

   localparam int SW    = SAMPLE_WIDTH;
   localparam int CW    = COUNT_WIDTH;
   localparam int SUM_W = SW + CW;
   localparam int SSQ_W = 2 * SW - 1 + CW;

   logic [CW-1:0]    count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SSQ_W-1:0] ssq_ff, ssq_in;
   logic             ovf_ff, ovf_in;

   logic             take;
   logic [CW-1:0]    base_count;
   logic [SUM_W-1:0] base_sum;
   logic [SSQ_W-1:0] base_ssq;
   logic             base_ovf;
   logic             count_full;
   logic             add_sample;
   logic [SUM_W-1:0] sample_ext;
   logic [SW-1:0]    sample_mag;
   logic [2*SW-1:0]  sample_sq;

   // Stall only when the snapshot queue has no room
   assign req_ready = snap_ready;
   assign take      = req_valid && req_ready;

   // Restart clears the totals before this sample counts
   assign base_count = req_flags.restart ? '0 : count_ff;
   assign base_sum   = req_flags.restart ? '0 : sum_ff;
   assign base_ssq   = req_flags.restart ? '0 : ssq_ff;
   assign base_ovf   = req_flags.restart ? 1'b0 : ovf_ff;

   assign count_full = &base_count;
   assign add_sample = req_flags.accept && !count_full;

   // Sign-extend the sample and square its magnitude
   assign sample_ext = {{CW{req_sample[SW-1]}}, req_sample};
   assign sample_mag = req_sample[SW-1] ? (~req_sample + 1'b1) : req_sample;
   assign sample_sq  = sample_mag * sample_mag;

   // Next totals after this transaction
   always_comb begin
      count_in = base_count;
      sum_in   = base_sum;
      ssq_in   = base_ssq;
      ovf_in   = base_ovf | (req_flags.accept && count_full);
      if (add_sample) begin
         count_in = base_count + 1'b1;
         sum_in   = base_sum + sample_ext;
         ssq_in   = base_ssq + SSQ_W'(sample_sq);
      end
   end

   // Hold totals, advance on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         ssq_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (take) begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         ssq_ff   <= ssq_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Queue a snapshot of the updated totals on report
   assign snap_valid = take && req_flags.report;
   assign snap_data  = {ovf_in, ssq_in, sum_in, count_in};

endmodule

`default_nettype wire

[rtl/rsd_queue.sv]
// Short queue of report snapshots between the front and back ends.
`default_nettype none

module rsd_queue #(
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [DATA_W-1:0] in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [DATA_W-1:0]      out_data
);
   import rsd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              push, pop;

   assign in_ready  = fill_ff != CNT_W'(QUEUE_DEPTH);
   assign out_valid = fill_ff != '0;
   assign out_data  = mem[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

[rtl/rsd_back.sv]
// Back end: sequential multiply, divide and square root of one snapshot per report.
`default_nettype none

module rsd_back #(
   parameter int SAMPLE_WIDTH = rsd_pkg::DEF_SAMPLE_WIDTH,
   parameter int COUNT_WIDTH  = rsd_pkg::DEF_COUNT_WIDTH,
   parameter int SNAP_W       = COUNT_WIDTH + (SAMPLE_WIDTH + COUNT_WIDTH)
                                + (2 * SAMPLE_WIDTH - 1 + COUNT_WIDTH) + 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   snap_valid,
   output logic                        snap_ready,
   input  wire logic [SNAP_W-1:0]      snap_data,
   output logic                        result_valid,
   input  wire logic                   result_ready,
   output rsd_pkg::rsd_result_type     result
);
   import rsd_pkg::*;

   localparam int SW     = SAMPLE_WIDTH;
   localparam int CW     = COUNT_WIDTH;
   localparam int SUM_W  = SW + CW;
   localparam int SSQ_W  = 2 * SW - 1 + CW;
   localparam int W      = 2 * SUM_W;
   localparam int DW     = 2 * CW;
   localparam int QW     = 2 * SW;
   localparam int STEP_W = $clog2(W + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_A,
      S_MUL_B,
      S_DIVIDE,
      S_ROOT,
      S_DONE
   } state_type;

   state_type         state_ff;
   logic [CW-1:0]     n_ff;
   logic              ovf_ff;
   logic              miss_ff;
   logic [SUM_W-1:0]  smag_ff;
   logic [DW-1:0]     den_ff;
   logic [W-1:0]      acc_ff;
   logic [W-1:0]      prod_ff;
   logic [W-1:0]      mcand_ff;
   logic [SUM_W-1:0]  mplier_ff;
   logic [DW:0]       rem_ff;
   logic [QW-1:0]     rn_ff;
   logic [QW-1:0]     res_ff;
   logic [QW-1:0]     bit_ff;
   logic [STEP_W-1:0] step_ff;
   rsd_result_type    out_ff;
   logic              out_valid_ff;

   // Snapshot fields
   logic [CW-1:0]     snap_count;
   logic [CW-1:0]     snap_count_dec;
   logic [SUM_W-1:0]  snap_sum;
   logic [SSQ_W-1:0]  snap_ssq;
   logic              snap_ovf;
   logic [SUM_W-1:0]  snap_smag;
   logic [DW-1:0]     den_mul;

   // Datapath next values
   logic [W-1:0]      mul_next;
   logic [W-1:0]      diff;
   logic [DW:0]       rem_shift;
   logic              rem_ge;
   logic [W-1:0]      div_next;
   logic [QW-1:0]     root_trial;
   logic              root_ge;
   logic [31:0]       n_wide;
   logic [63:0]       res_wide;
   logic [OUT_W-1:0]  count_sat;
   logic [OUT_W-1:0]  sd_sat;

   assign snap_count     = snap_data[CW-1:0];
   assign snap_count_dec = snap_count - 1'b1;
   assign snap_sum       = snap_data[CW +: SUM_W];
   assign snap_ssq       = snap_data[CW+SUM_W +: SSQ_W];
   assign snap_ovf       = snap_data[SNAP_W-1];
   assign snap_smag      = snap_sum[SUM_W-1] ? (~snap_sum + 1'b1) : snap_sum;
   assign den_mul        = snap_count * snap_count_dec;

   // Shift-add multiply: one multiplier bit per cycle, MSB first
   assign mul_next = {acc_ff[W-2:0], 1'b0} + (mplier_ff[SUM_W-1] ? mcand_ff : '0);
   // Spread N*SS - S*S, clamped at zero
   assign diff     = (prod_ff >= mul_next) ? (prod_ff - mul_next) : '0;

   // Restoring divide: one quotient bit per cycle into the low end of acc
   assign rem_shift = {rem_ff[DW-1:0], acc_ff[W-1]};
   assign rem_ge    = rem_shift >= {1'b0, den_ff};
   assign div_next  = {acc_ff[W-2:0], rem_ge};

   // Digit-by-digit square root: one result bit per cycle
   assign root_trial = res_ff + bit_ff;
   assign root_ge    = rn_ff >= root_trial;

   // Saturate wide values to the result fields
   assign n_wide    = 32'(n_ff);
   assign res_wide  = 64'(res_ff);
   assign count_sat = (n_wide > 32'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(n_ff);
   assign sd_sat    = (res_wide > 64'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(res_ff);

   assign snap_ready   = state_ff == S_IDLE;
   assign result_valid = out_valid_ff;
   assign result       = out_ff;

   // Sequence the evaluation and hold the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         // Drop a taken response unless the done state loads the next one
         if (result_ready && state_ff != S_DONE) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (snap_valid) begin
                  n_ff      <= snap_count;
                  ovf_ff    <= snap_ovf;
                  smag_ff   <= snap_smag;
                  den_ff    <= den_mul;
                  miss_ff   <= snap_count < CW'(2);
                  mcand_ff  <= W'(snap_ssq);
                  mplier_ff <= SUM_W'(snap_count);
                  acc_ff    <= '0;
                  res_ff    <= '0;
                  step_ff   <= '0;
                  state_ff  <= (snap_count < CW'(2)) ? S_DONE : S_MUL_A;
               end
            end
            S_MUL_A: begin
               acc_ff    <= mul_next;
               mplier_ff <= {mplier_ff[SUM_W-2:0], 1'b0};
               step_ff   <= step_ff + 1'b1;
               if (step_ff == STEP_W'(SUM_W - 1)) begin
                  prod_ff   <= mul_next;
                  mcand_ff  <= W'(smag_ff);
                  mplier_ff <= smag_ff;
                  acc_ff    <= '0;
                  step_ff   <= '0;
                  state_ff  <= S_MUL_B;
               end
            end
            S_MUL_B: begin
               acc_ff    <= mul_next;
               mplier_ff <= {mplier_ff[SUM_W-2:0], 1'b0};
               step_ff   <= step_ff + 1'b1;
               if (step_ff == STEP_W'(SUM_W - 1)) begin
                  acc_ff   <= diff;
                  rem_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= S_DIVIDE;
               end
            end
            S_DIVIDE: begin
               acc_ff  <= div_next;
               rem_ff  <= rem_ge ? (rem_shift - {1'b0, den_ff}) : rem_shift;
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(W - 1)) begin
                  rn_ff    <= div_next[QW-1:0];
                  res_ff   <= '0;
                  bit_ff   <= QW'(1) << (QW - 2);
                  step_ff  <= '0;
                  state_ff <= S_ROOT;
               end
            end
            S_ROOT: begin
               if (root_ge) begin
                  rn_ff  <= rn_ff - root_trial;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff  <= bit_ff >> 2;
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(SW - 1)) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!out_valid_ff || result_ready) begin
                  out_ff.sample_count <= count_sat;
                  out_ff.std_dev      <= sd_sat;
                  out_ff.missing      <= miss_ff;
                  out_ff.saturated    <= ovf_ff;
                  out_valid_ff        <= 1'b1;
                  state_ff            <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/running_sample_std_dev.sv]
// Top level of the running sample standard deviation block.
`default_nettype none

// Running sample standard deviation. Every request transaction carries a
// signed sample and three flags; restart clears the totals first, accept adds
// the sample (dropped, with the saturated flag set, once the count is full),
// and report asks for one response after the update. Samples are taken one per
// cycle; the front end stalls only when two reports are already queued and
// not yet evaluated. Each report is evaluated in the back end by one shared
// shift-add multiplier, a restoring divider and a digit-by-digit square root,
// or goes straight to the result when fewer than two samples are counted. The
// response reports the count, floor(sqrt((N*SS - S*S) / (N*(N-1)))) and the
// missing and saturated flags, both fields saturating at 65535.
module running_sample_std_dev #(
   parameter int SAMPLE_WIDTH = rsd_pkg::DEF_SAMPLE_WIDTH,
   parameter int COUNT_WIDTH  = rsd_pkg::DEF_COUNT_WIDTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // op_sample in the low SAMPLE_WIDTH bits
   input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     req_tdata,
   // bit 0 accept, bit 1 restart, bit 2 report
   input  wire logic [2:0]                            req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // bits 15:0 sample_count, bits 31:16 std_dev
   output logic [2*rsd_pkg::OUT_W-1:0]                rsp_tdata,
   // bit 0 missing, bit 1 saturated
   output logic [1:0]                                 rsp_tuser
);
   import rsd_pkg::*;

   localparam int SNAP_W = COUNT_WIDTH + (SAMPLE_WIDTH + COUNT_WIDTH)
                           + (2 * SAMPLE_WIDTH - 1 + COUNT_WIDTH) + 1;

   rsd_flags_type     req_flags;
   logic              push_valid, push_ready;
   logic [SNAP_W-1:0] push_data;
   logic              pop_valid, pop_ready;
   logic [SNAP_W-1:0] pop_data;
   rsd_result_type    result;

   assign req_flags = req_tuser;

   // Accumulate samples
   rsd_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COUNT_WIDTH  (COUNT_WIDTH),
      .SNAP_W       (SNAP_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_sample (req_tdata[SAMPLE_WIDTH-1:0]),
      .req_flags  (req_flags),
      .snap_valid (push_valid),
      .snap_ready (push_ready),
      .snap_data  (push_data)
   );

   // Queue report snapshots
   rsd_queue #(
      .DATA_W (SNAP_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   // Evaluate reports
   rsd_back #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COUNT_WIDTH  (COUNT_WIDTH),
      .SNAP_W       (SNAP_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .snap_valid   (pop_valid),
      .snap_ready   (pop_ready),
      .snap_data    (pop_data),
      .result_valid (rsp_tvalid),
      .result_ready (rsp_tready),
      .result       (result)
   );

   assign rsp_tdata = {result.std_dev, result.sample_count};
   assign rsp_tuser = {result.saturated, result.missing};

endmodule

`default_nettype wire

[rtl/rsd_checker.sv]
// Port-level checks of the running standard deviation block, bound to its top level.
`default_nettype none

`include "running_sample_std_dev_assert.svh"

module rsd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // Hold a stalled response
   `RSD_ASSERT_NXT(a_rsp_hold, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // Report zero spread when fewer than two samples
   `RSD_ASSERT_IMP(a_missing_zero, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata[31:16] == 16'd0)

   // Flag missing exactly when the count is below two
   `RSD_ASSERT_IMP(a_missing_count, reset, rsp_tvalid, rsp_tuser[0] == (rsp_tdata[15:0] < 16'd2))

   // Drop any pending response on reset
   `RSD_ASSERT_NXT(a_reset_idle, 1'b0, reset, !rsp_tvalid)

endmodule

bind running_sample_std_dev rsd_checker u_rsd_checker (.*);

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench of the running sample standard deviation block.
`default_nettype none

module tb;
   import rsd_pkg::*;

   localparam int SW         = DEF_SAMPLE_WIDTH;
   localparam int CW         = DEF_COUNT_WIDTH;
   localparam int DATA_W     = ((SW + 7) / 8) * 8;
   localparam int SAMPLE_MAX = 2 ** (SW - 1) - 1;
   localparam int SAMPLE_MIN = -(2 ** (SW - 1));
   localparam logic [CW-1:0] COUNT_FULL = '1;
   // evaluation time of one report plus some margin
   localparam int SETTLE_CYCLES = 4 * (SW + CW) + SW + 2 + 32;
   localparam longint CYCLE_LIMIT = 2_000_000;
   localparam int RANDOM_ITEMS = 1500;

   // Running totals of the block and the reports they lead to
   class spread_scoreboard;
      logic [CW-1:0]          n_total;
      logic signed [SW+CW-1:0] sum_total;
      logic [2*SW+CW-2:0]     square_total;
      logic                   dropped_flag;
      rsd_result_type         pending_reports[$];
      int                     mismatches;
      int                     reports_checked;
      int                     samples_dropped;

      function void clear_totals();
         n_total      = '0;
         sum_total    = '0;
         square_total = '0;
         dropped_flag = 1'b0;
      endfunction

      // floor(sqrt(floor((N*SS - S*S) / (N*(N-1))))), clamped to the output width
      function logic [OUT_W-1:0] std_dev_of_totals();
         bit [127:0]     scaled_squares;
         bit [127:0]     square_of_sum;
         bit [127:0]     quotient;
         bit [127:0]     trial;
         bit [127:0]     root;
         bit [SW+CW-1:0] sum_mag;
         if (n_total < 2) return '0;
         sum_mag = (sum_total < 0) ? -sum_total : sum_total;
         scaled_squares = 128'(n_total) * 128'(square_total);
         square_of_sum  = 128'(sum_mag) * 128'(sum_mag);
         if (scaled_squares < square_of_sum) return '0;
         quotient = (scaled_squares - square_of_sum) /
                    (128'(n_total) * 128'(n_total - 1'b1));
         // build the root one bit at a time, most significant first
         root = '0;
         for (int b = 47; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial <= quotient) root = trial;
         end
         return (root > OUT_MAX) ? OUT_W'(OUT_MAX) : root[OUT_W-1:0];
      endfunction

      // Apply one accepted request transaction to the totals
      function void note_request(logic signed [SW-1:0] sample, rsd_flags_type flags);
         longint         value;
         rsd_result_type result;
         value = sample;
         if (flags.restart) clear_totals();
         if (flags.accept) begin
            if (n_total == COUNT_FULL) begin
               dropped_flag = 1'b1;
               samples_dropped++;
            end else begin
               n_total++;
               sum_total    += value;
               square_total += value * value;
            end
         end
         if (flags.report) begin
            result.sample_count = (n_total > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(n_total);
            result.std_dev      = std_dev_of_totals();
            result.missing      = (n_total < 2);
            result.saturated    = dropped_flag;
            pending_reports.push_back(result);
         end
      endfunction

      function void note_mismatch(string field, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      endfunction

      // Compare one response transaction with the oldest pending report
      function void check_response(logic [2*OUT_W-1:0] data, logic [1:0] flags);
         rsd_result_type got;
         rsd_result_type want;
         got = {flags, data};
         if (pending_reports.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            return;
         end
         want = pending_reports.pop_front();
         reports_checked++;
         if (got.sample_count !== want.sample_count)
            note_mismatch("sample_count", want.sample_count, got.sample_count);
         if (got.std_dev !== want.std_dev)
            note_mismatch("std_dev", want.std_dev, got.std_dev);
         if (got.missing !== want.missing)
            note_mismatch("missing", want.missing, got.missing);
         if (got.saturated !== want.saturated)
            note_mismatch("saturated", want.saturated, got.saturated);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata = '0;   // op_sample
   logic [2:0]           req_tuser = '0;   // accept, restart, report
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [2*OUT_W-1:0]   rsp_tdata;        // sample_count, std_dev
   logic [1:0]           rsp_tuser;        // missing, saturated

   spread_scoreboard sb = new;
   bit     sender_idles = 1'b1;
   bit     sink_idles = 1'b1;
   int     requests_sent = 0;
   longint cycles = 0;

   running_sample_std_dev #(.SAMPLE_WIDTH(SW), .COUNT_WIDTH(CW)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached, %0d reports still pending", $time,
                  sb.pending_reports.size());
         $display("** running_sample_std_dev: FAILED **");
         $finish;
      end
   end

   // Send one request transaction, idling first when enabled; valid stays high after it
   task automatic send_request(input logic signed [SW-1:0] sample, input logic accept_bit,
                               input logic restart_bit, input logic report_bit);
      int            gap;
      rsd_flags_type flags;
      gap = sender_idles ? $urandom_range(0, 7) : 0;
      flags.accept  = accept_bit;
      flags.restart = restart_bit;
      flags.report  = report_bit;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'(sample);
      req_tuser  <= flags;
      do @(posedge clock); while (!req_tready);
      sb.note_request(sample, flags);
      requests_sent++;
   endtask

   // Hold the sender until every pending report has come back, then let the block settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Draw a sample: full range, a cluster around a center, or an extreme value
   function automatic logic signed [SW-1:0] pick_sample(int mode, int center, int spread);
      int v;
      case (mode)
         0: v = $urandom;
         1: begin
            v = center + int'($urandom_range(0, 2 * spread)) - spread;
            if (v > SAMPLE_MAX) v = SAMPLE_MAX;
            if (v < SAMPLE_MIN) v = SAMPLE_MIN;
         end
         default: begin
            case ($urandom_range(0, 3))
               0: v = SAMPLE_MIN;
               1: v = SAMPLE_MAX;
               2: v = 0;
               default: v = -1;
            endcase
         end
      endcase
      return v[SW-1:0];
   endfunction

   // Corner cases: empty and single-sample reports, extremes, restart combinations
   task automatic directed_checks();
      send_request(SW'(0), 1'b0, 1'b0, 1'b1);
      send_request(SW'(SAMPLE_MAX), 1'b1, 1'b0, 1'b1);
      send_request(SW'(SAMPLE_MIN), 1'b1, 1'b0, 1'b1);
      send_request(SW'(SAMPLE_MIN), 1'b0, 1'b0, 1'b1);
      send_request(SW'(0), 1'b1, 1'b0, 1'b1);
      send_request(SW'(-1), 1'b1, 1'b0, 1'b0);
      send_request(SW'(1), 1'b1, 1'b0, 1'b1);
      send_request(SW'(12345), 1'b1, 1'b1, 1'b1);
      send_request(SW'(12345), 1'b1, 1'b0, 1'b1);
      send_request(SW'(SAMPLE_MIN), 1'b1, 1'b1, 1'b0);
      send_request(SW'(SAMPLE_MIN), 1'b1, 1'b0, 1'b1);
      send_request(SW'(SAMPLE_MAX), 1'b0, 1'b1, 1'b1);
      send_request(SW'(-21846), 1'b1, 1'b0, 1'b0);
      send_request(SW'(21845), 1'b1, 1'b0, 1'b0);
      send_request(SW'(SAMPLE_MAX), 1'b1, 1'b0, 1'b1);
      send_request(SW'(SAMPLE_MIN), 1'b0, 1'b1, 1'b0);
      send_request(SW'(7), 1'b1, 1'b0, 1'b1);
      send_request(SW'(-7), 1'b1, 1'b0, 1'b1);
   endtask

   // Sessions of restart, accepted samples and reports, with some noise in between
   task automatic random_sessions();
      int sent;
      int len;
      int mode;
      int center;
      int spread;
      bit paused;
      sent   = 0;
      paused = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         sender_idles = ($urandom_range(0, 3) != 0);
         sink_idles   = ($urandom_range(0, 3) != 0);
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            drain_results();
            paused = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_request(SW'($urandom), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            sent++;
         end else begin
            len    = $urandom_range(1, 40);
            mode   = $urandom_range(0, 2);
            center = int'($urandom_range(0, 65535)) - 32768;
            spread = 1 << $urandom_range(0, 15);
            for (int i = 0; i < len; i++) begin
               send_request(pick_sample(mode, center, spread),
                            $urandom_range(0, 9) != 0,
                            (i == 0) || ($urandom_range(0, 49) == 0),
                            (i == len - 1) || ($urandom_range(0, 4) == 0));
               sent++;
            end
         end
      end
   endtask

   // Accept responses with random stalls
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = sink_idles ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_tdata, rsp_tuser);
      end
   end

   // Main sequence
   initial begin
      int directed_count;
      sb.clear_totals();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_checks();
      directed_count = requests_sent;
      drain_results();
      random_sessions();
      drain_results();
      $display("Run covered %0d requests: %0d corner cases, rest in random restart sessions.",
               requests_sent, directed_count);
      $display("Checked %0d reports, %0d samples dropped at full count, %0d mismatches.",
               sb.reports_checked, sb.samples_dropped, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
         $display("** running_sample_std_dev: PASSED **");
      end else begin
         $display("** running_sample_std_dev: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/rsd_pkg.sv
rtl/rsd_front.sv
rtl/rsd_queue.sv
rtl/rsd_back.sv
rtl/running_sample_std_dev.sv
rtl/rsd_checker.sv
dv/tb.sv
